// ----- src/ght_pkg.sv -----
// ght_pkg: shared widths, operation and status codes, and structs for the
// generational handle table. No dependencies.
package ght_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int GEN_W  = 32;
    localparam int DATA_W = 64;

    localparam logic [GEN_W-1:0] INITIAL_GENERATION = 32'd1;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_DESTROY  = 3'd1,
        OP_UPDATE   = 3'd2,
        OP_GET      = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DESC = 2'd1,
        ST_STALE    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Free stack entry: slot index and the generation it was freed with.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] idx;
    } stk_entry_t;

    // Captured request.
    typedef struct packed {
        logic [2:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        logic [DATA_W-1:0] data;
        logic              dvalid;
    } req_t;

    // Result of one request.
    typedef struct packed {
        logic              success;
        logic [1:0]        status;
        logic [IDX_W-1:0]  new_index;
        logic [GEN_W-1:0]  new_generation;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  live_count;
    } res_t;

    // State updates computed by the execute stage.
    typedef struct packed {
        logic              gen_we;
        logic [IDX_W-1:0]  gen_addr;
        logic [GEN_W-1:0]  gen_wdata;
        logic              pay_we;
        logic [IDX_W-1:0]  pay_addr;
        logic [DATA_W-1:0] pay_wdata;
        logic              stk_we;
        logic [IDX_W-1:0]  stk_addr;
        stk_entry_t        stk_wdata;
        logic              occ_set;
        logic              occ_clr;
        logic              occ_clear_all;
        logic [IDX_W-1:0]  occ_addr;
        logic [CNT_W-1:0]  free_top_next;
        logic [CNT_W-1:0]  high_water_next;
        logic [CNT_W-1:0]  body_next;
    } upd_t;

endpackage

// ----- src/ght_ram.sv -----
// ght_ram: generic single-write, single-read synchronous RAM with registered read
// data, held while read enable is low. No dependencies.
module ght_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ght_exec.sv -----
// ght_exec: execute stage. Resolves the handle against read data and
// computes the result and all state updates. Uses ght_pkg.
module ght_exec (
    input  ght_pkg::req_t                req,
    input  logic [ght_pkg::GEN_W-1:0]    gen_rd,
    input  logic [ght_pkg::DATA_W-1:0]   pay_rd,
    input  ght_pkg::stk_entry_t          stk_rd,
    input  logic                         occ_hit,
    input  logic [ght_pkg::CNT_W-1:0]    free_top,
    input  logic [ght_pkg::CNT_W-1:0]    high_water,
    input  logic [ght_pkg::CNT_W-1:0]    body,
    output ght_pkg::res_t                res,
    output ght_pkg::upd_t                upd
);

    logic                        resolves;
    logic [ght_pkg::GEN_W-1:0]   gen_inc;
    logic [ght_pkg::GEN_W-1:0]   gen_adv;

    assign resolves = (req.gen != '0)
                   && ({1'b0, req.idx} < high_water)
                   && occ_hit
                   && (gen_rd == req.gen);

    // generation advance skips 0
    assign gen_inc = gen_rd + ght_pkg::GEN_W'(1);
    assign gen_adv = (gen_inc == '0) ? ght_pkg::GEN_W'(1) : gen_inc;

    always_comb
    begin
        logic                       got;
        logic [ght_pkg::IDX_W-1:0]  slot;
        logic [ght_pkg::GEN_W-1:0]  sgen;

        got  = 1'b0;
        slot = '0;
        sgen = '0;

        res        = '0;
        res.status = ght_pkg::ST_OK;

        upd                 = '0;
        upd.gen_addr        = req.idx;
        upd.pay_addr        = req.idx;
        upd.pay_wdata       = req.data;
        upd.stk_addr        = free_top[ght_pkg::IDX_W-1:0];
        upd.stk_wdata.idx   = req.idx;
        upd.stk_wdata.gen   = gen_adv;
        upd.occ_addr        = req.idx;
        upd.free_top_next   = free_top;
        upd.high_water_next = high_water;
        upd.body_next       = body;

        case (req.op)
            ght_pkg::OP_ADD:
            begin
                if (!req.dvalid)
                begin
                    res.status = ght_pkg::ST_BAD_DESC;
                end
                else if (free_top != '0)
                begin
                    got               = 1'b1;
                    slot              = stk_rd.idx;
                    sgen              = stk_rd.gen;
                    upd.free_top_next = free_top - ght_pkg::CNT_W'(1);
                end
                else if (high_water < ght_pkg::CNT_W'(ght_pkg::SLOTS))
                begin
                    got                 = 1'b1;
                    slot                = high_water[ght_pkg::IDX_W-1:0];
                    sgen                = ght_pkg::INITIAL_GENERATION;
                    upd.high_water_next = high_water + ght_pkg::CNT_W'(1);
                    upd.gen_we          = 1'b1;
                    upd.gen_addr        = slot;
                    upd.gen_wdata       = ght_pkg::INITIAL_GENERATION;
                end
                else
                begin
                    res.status = ght_pkg::ST_FULL;
                end
                if (got)
                begin
                    upd.occ_set        = 1'b1;
                    upd.occ_addr       = slot;
                    upd.pay_we         = 1'b1;
                    upd.pay_addr       = slot;
                    upd.body_next      = body + ght_pkg::CNT_W'(1);
                    res.success        = 1'b1;
                    res.new_index      = slot;
                    res.new_generation = sgen;
                end
            end
            ght_pkg::OP_DESTROY:
            begin
                if (!resolves)
                begin
                    res.status = ght_pkg::ST_STALE;
                end
                else
                begin
                    upd.occ_clr   = 1'b1;
                    upd.gen_we    = 1'b1;
                    upd.gen_wdata = gen_adv;
                    if (free_top < ght_pkg::CNT_W'(ght_pkg::SLOTS))
                    begin
                        upd.stk_we        = 1'b1;
                        upd.free_top_next = free_top + ght_pkg::CNT_W'(1);
                    end
                    if (body != '0)
                    begin
                        upd.body_next = body - ght_pkg::CNT_W'(1);
                    end
                    res.success = 1'b1;
                end
            end
            ght_pkg::OP_UPDATE:
            begin
                if (!req.dvalid)
                begin
                    res.status = ght_pkg::ST_BAD_DESC;
                end
                else if (!resolves)
                begin
                    res.status = ght_pkg::ST_STALE;
                end
                else
                begin
                    upd.pay_we  = 1'b1;
                    res.success = 1'b1;
                end
            end
            ght_pkg::OP_GET:
            begin
                if (!resolves)
                begin
                    res.status = ght_pkg::ST_STALE;
                end
                else
                begin
                    res.read_data = pay_rd;
                    res.success   = 1'b1;
                end
            end
            ght_pkg::OP_CONTAINS:
            begin
                if (!resolves)
                begin
                    res.status = ght_pkg::ST_STALE;
                end
                else
                begin
                    res.success = 1'b1;
                end
            end
            ght_pkg::OP_CLEAR:
            begin
                upd.occ_clear_all   = 1'b1;
                upd.free_top_next   = '0;
                upd.high_water_next = '0;
                upd.body_next       = '0;
                res.success         = 1'b1;
            end
            default:
            begin
                // undefined codes: no effect
            end
        endcase

        res.live_count = upd.body_next;
    end

endmodule

// ----- src/generational_handle_table.sv -----
// generational_handle_table: top level. Request capture, slot memories,
// occupied bits, counters and output register. Uses ght_pkg, ght_ram, ght_exec.
//
//  channel  | dir | handshake                    | contents
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | request: op, handle, payload
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | result: status, new handle, data
//
// Each request is accepted in S_IDLE, which issues the reads of the
// generation, payload and free-stack memories; S_EXEC then resolves the
// handle and writes back. The single read port of each memory sets this split.
// A result waits in the output register; the next request is still accepted
// and holds in its execute cycle only while that register stays full.
// Reset (asynchronous, active low) empties the table at once: occupied bits
// and counters are flops; the memories need no clearing.
module generational_handle_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [5:0] handle_index, [37:6] handle_generation, [101:38] entry_data, zero pad
    input  logic [103:0] s_axis_tdata,
    // [2:0] operation, [3] data_valid
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] new_index, [37:6] new_generation, [101:38] read_data,
    // [108:102] live_count, zero pad
    output logic [111:0] m_axis_tdata,
    // [0] success, [2:1] status
    output logic [2:0]   m_axis_tuser
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    ght_pkg::req_t                  req_reg;
    logic [ght_pkg::SLOTS-1:0]      occ_reg;
    logic [ght_pkg::CNT_W-1:0]      free_top_reg;
    logic [ght_pkg::CNT_W-1:0]      high_water_reg;
    logic [ght_pkg::CNT_W-1:0]      body_reg;
    logic                           out_valid_reg;
    ght_pkg::res_t                  out_reg;

    logic                           accept;
    logic                           commit;
    logic [ght_pkg::CNT_W-1:0]      ft_dec;
    logic [ght_pkg::GEN_W-1:0]      gen_rd;
    logic [ght_pkg::DATA_W-1:0]     pay_rd;
    ght_pkg::stk_entry_t            stk_rd;
    ght_pkg::res_t                  res;
    ght_pkg::upd_t                  upd;
    logic [ght_pkg::IDX_W-1:0]      in_idx;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // execute commits when the output register is free or being drained
    assign commit        = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    assign in_idx        = s_axis_tdata[5:0];
    assign ft_dec        = free_top_reg - ght_pkg::CNT_W'(1);

    // slot generation
    ght_ram #(
        .WIDTH  (ght_pkg::GEN_W),
        .ADDR_W (ght_pkg::IDX_W)
    ) u_gen_ram (
        .clk   (clk),
        .we    (commit && upd.gen_we),
        .waddr (upd.gen_addr),
        .wdata (upd.gen_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (gen_rd)
    );

    // slot payload
    ght_ram #(
        .WIDTH  (ght_pkg::DATA_W),
        .ADDR_W (ght_pkg::IDX_W)
    ) u_pay_ram (
        .clk   (clk),
        .we    (commit && upd.pay_we),
        .waddr (upd.pay_addr),
        .wdata (upd.pay_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (pay_rd)
    );

    // free stack; top entry prefetched on accept
    ght_ram #(
        .WIDTH  ($bits(ght_pkg::stk_entry_t)),
        .ADDR_W (ght_pkg::IDX_W)
    ) u_stk_ram (
        .clk   (clk),
        .we    (commit && upd.stk_we),
        .waddr (upd.stk_addr),
        .wdata (upd.stk_wdata),
        .re    (accept),
        .raddr (ft_dec[ght_pkg::IDX_W-1:0]),
        .rdata (stk_rd)
    );

    ght_exec u_exec (
        .req        (req_reg),
        .gen_rd     (gen_rd),
        .pay_rd     (pay_rd),
        .stk_rd     (stk_rd),
        .occ_hit    (occ_reg[req_reg.idx]),
        .free_top   (free_top_reg),
        .high_water (high_water_reg),
        .body       (body_reg),
        .res        (res),
        .upd        (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            occ_reg        <= '0;
            free_top_reg   <= '0;
            high_water_reg <= '0;
            body_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            // a commit refills the output register in the cycle it drains
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg.op     <= s_axis_tuser[2:0];
                        req_reg.dvalid <= s_axis_tuser[3];
                        req_reg.idx    <= in_idx;
                        req_reg.gen    <= s_axis_tdata[37:6];
                        req_reg.data   <= s_axis_tdata[101:38];
                        state_reg      <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        if (upd.occ_clear_all)
                        begin
                            occ_reg <= '0;
                        end
                        else if (upd.occ_set)
                        begin
                            occ_reg[upd.occ_addr] <= 1'b1;
                        end
                        else if (upd.occ_clr)
                        begin
                            occ_reg[upd.occ_addr] <= 1'b0;
                        end
                        free_top_reg   <= upd.free_top_next;
                        high_water_reg <= upd.high_water_next;
                        body_reg       <= upd.body_next;
                        out_reg        <= res;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_reg.live_count,
                            out_reg.read_data,
                            out_reg.new_generation,
                            out_reg.new_index};
    assign m_axis_tuser  = {out_reg.status, out_reg.success};

    // every claimed slot is either live or waiting on the free stack
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, body_reg} + {1'b0, free_top_reg}) == {1'b0, high_water_reg})
        else $error("live plus free slots differ from claimed slots");

    a_live_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == 32'(body_reg))
        else $error("occupied bits disagree with live count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && out_valid_reg && !m_axis_tready) |=>
        (state_reg == S_EXEC && $stable(body_reg) && $stable(free_top_reg)))
        else $error("execute committed while output register was full");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= high_water_reg)
        else $error("free stack deeper than claimed slots");

endmodule

// ----- tb/sv/tb_generational_handle_table.sv -----
// tb_generational_handle_table: self-checking testbench for the handle table.
// Predicts every result from its own copy of the slot state. Drives the request
// and result streams with random gaps. Depends on ght_pkg and generational_handle_table.
module tb_generational_handle_table;

    // Operation codes the block does not define; it must answer them with a no-op.
    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    // Cycles with no transfer on either stream before the run is declared hung.
    // The longest legal silence is the output hold of HOLD_CYCLES.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [5:0] handle_index, [37:6] handle_generation, [101:38] entry_data, zero pad
    logic [103:0] s_axis_tdata = '0;
    // [2:0] operation, [3] data_valid
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [5:0] new_index, [37:6] new_generation, [101:38] read_data,
    // [108:102] live_count, zero pad
    logic [111:0] m_axis_tdata;
    // [0] success, [2:1] status
    logic [2:0]   m_axis_tuser;

    generational_handle_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table: occupancy, generations, payloads, LIFO of
    // freed slots, the claimed-slot mark and the live count.
    // ------------------------------------------------------------------
    bit                         slot_live [ght_pkg::SLOTS];
    logic [ght_pkg::GEN_W-1:0]  slot_gen  [ght_pkg::SLOTS];
    logic [ght_pkg::DATA_W-1:0] slot_word [ght_pkg::SLOTS];
    logic [ght_pkg::IDX_W-1:0]  free_list [ght_pkg::SLOTS];
    int unsigned      free_depth = 0;
    int unsigned      claimed = 0;
    int unsigned      live_total = 0;

    ght_pkg::res_t predicted_outcomes[$];

    int errors = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int adds_granted = 0;
    int full_hits = 0;
    int stale_hits = 0;
    int bad_desc_hits = 0;
    int clears_seen = 0;
    int undef_seen = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Applies one request to the shadow table and returns the result it must give.
    function automatic ght_pkg::res_t predict_outcome(input ght_pkg::req_t r);
        ght_pkg::res_t o;
        int unsigned slot;
        bit hit;
        o = '0;
        o.status = ght_pkg::ST_OK;
        // A handle resolves only for a nonzero generation on a claimed, live slot
        // whose generation matches.
        hit = (r.gen != '0) && (r.idx < claimed) && slot_live[r.idx]
              && (slot_gen[r.idx] == r.gen);
        case (r.op)
            ght_pkg::OP_ADD:
            begin
                if (!r.dvalid)
                    o.status = ght_pkg::ST_BAD_DESC;
                else if (free_depth > 0 || claimed < ght_pkg::SLOTS)
                begin
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        slot = free_list[free_depth];
                    end
                    else
                    begin
                        // Fresh slot: generation starts over, even after a clear.
                        slot = claimed;
                        claimed++;
                        slot_gen[slot] = ght_pkg::INITIAL_GENERATION;
                    end
                    slot_live[slot] = 1'b1;
                    slot_word[slot] = r.data;
                    live_total++;
                    o.success = 1'b1;
                    o.new_index = slot[ght_pkg::IDX_W-1:0];
                    o.new_generation = slot_gen[slot];
                end
                else
                    o.status = ght_pkg::ST_FULL;
            end
            ght_pkg::OP_DESTROY:
            begin
                if (!hit)
                    o.status = ght_pkg::ST_STALE;
                else
                begin
                    slot_live[r.idx] = 1'b0;
                    slot_word[r.idx] = '0;
                    // Generation advances and skips zero on wrap.
                    slot_gen[r.idx] = slot_gen[r.idx] + ght_pkg::GEN_W'(1);
                    if (slot_gen[r.idx] == '0)
                        slot_gen[r.idx] = ght_pkg::GEN_W'(1);
                    if (free_depth < ght_pkg::SLOTS)
                    begin
                        free_list[free_depth] = r.idx;
                        free_depth++;
                    end
                    if (live_total > 0)
                        live_total--;
                    o.success = 1'b1;
                end
            end
            ght_pkg::OP_UPDATE:
            begin
                // Descriptor check comes before the handle check.
                if (!r.dvalid)
                    o.status = ght_pkg::ST_BAD_DESC;
                else if (!hit)
                    o.status = ght_pkg::ST_STALE;
                else
                begin
                    slot_word[r.idx] = r.data;
                    o.success = 1'b1;
                end
            end
            ght_pkg::OP_GET:
            begin
                if (!hit)
                    o.status = ght_pkg::ST_STALE;
                else
                begin
                    o.read_data = slot_word[r.idx];
                    o.success = 1'b1;
                end
            end
            ght_pkg::OP_CONTAINS:
            begin
                if (!hit)
                    o.status = ght_pkg::ST_STALE;
                else
                    o.success = 1'b1;
            end
            ght_pkg::OP_CLEAR:
            begin
                for (int k = 0; k < ght_pkg::SLOTS; k++)
                    slot_live[k] = 1'b0;
                free_depth = 0;
                claimed = 0;
                live_total = 0;
                o.success = 1'b1;
            end
            default: ;
        endcase
        o.live_count = live_total[ght_pkg::CNT_W-1:0];
        return o;
    endfunction

    // Handle parts are taken as plain numbers and cut to the field widths.
    function automatic ght_pkg::req_t mk_req(input logic [2:0] op, input int unsigned idx,
                                             input int unsigned gen,
                                             input logic [ght_pkg::DATA_W-1:0] data,
                                             input logic dvalid);
        ght_pkg::req_t r;
        r.op = op;
        r.idx = ght_pkg::IDX_W'(idx);
        r.gen = ght_pkg::GEN_W'(gen);
        r.data = data;
        r.dvalid = dvalid;
        return r;
    endfunction

    // Random request steered by the shadow table: mostly valid handles, with
    // stale, zero-generation and arbitrary handles mixed in.
    function automatic ght_pkg::req_t compose_request(input int add_w);
        ght_pkg::req_t r;
        int pick;
        int h;
        int unsigned live_idx[$];
        r = mk_req(ght_pkg::OP_ADD, $urandom, $urandom, {$urandom, $urandom},
                   $urandom_range(99) < 92);
        if ($urandom_range(99) < add_w)
            return r;
        pick = $urandom_range(99);
        if (pick < 25)      r.op = ght_pkg::OP_DESTROY;
        else if (pick < 45) r.op = ght_pkg::OP_UPDATE;
        else if (pick < 70) r.op = ght_pkg::OP_GET;
        else if (pick < 92) r.op = ght_pkg::OP_CONTAINS;
        else if (pick < 94) r.op = ght_pkg::OP_CLEAR;
        else if (pick < 97) r.op = OP_UNDEF_LO;
        else                r.op = OP_UNDEF_HI;
        for (int k = 0; k < claimed; k++)
            if (slot_live[k])
                live_idx.insert(live_idx.size(), k);
        h = $urandom_range(99);
        if (h < 70 && live_idx.size() > 0)
        begin
            r.idx = ght_pkg::IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
            r.gen = slot_gen[r.idx];
        end
        else if (h < 85 && free_depth > 0)
        begin
            // Handle to a freed slot, one generation behind.
            r.idx = free_list[$urandom_range(free_depth - 1)];
            r.gen = slot_gen[r.idx] - ght_pkg::GEN_W'(1);
        end
        else if (h < 90 && live_idx.size() > 0)
        begin
            r.idx = ght_pkg::IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
            r.gen = slot_gen[r.idx] + ght_pkg::GEN_W'(1);
        end
        else if (h < 94)
            r.gen = '0;
        return r;
    endfunction

    // Offers one request and waits for the handshake; tvalid stays high after.
    task automatic issue_request(input ght_pkg::req_t r);
        ght_pkg::res_t o;
        s_axis_tdata <= {2'b00, r.data, r.gen, r.idx};
        s_axis_tuser <= {r.dvalid, r.op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        o = predict_outcome(r);
        predicted_outcomes.insert(predicted_outcomes.size(), o);
        requests_sent++;
        if (r.op == ght_pkg::OP_ADD && o.success)   adds_granted++;
        if (o.status == ght_pkg::ST_FULL)           full_hits++;
        if (o.status == ght_pkg::ST_STALE)          stale_hits++;
        if (o.status == ght_pkg::ST_BAD_DESC)       bad_desc_hits++;
        if (r.op == ght_pkg::OP_CLEAR)              clears_seen++;
        if (r.op == OP_UNDEF_LO || r.op == OP_UNDEF_HI) undef_seen++;
    endtask

    task automatic sender_gap;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sender goes quiet until every outstanding result has been checked.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_outcomes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed;
        logic [ght_pkg::DATA_W-1:0] w;
        w = {$urandom, $urandom};
        issue_request(mk_req(ght_pkg::OP_ADD, 0, 0, w, 1'b0));           // bad descriptor
        issue_request(mk_req(ght_pkg::OP_GET, 0, 1, '0, 1'b1));          // nothing claimed yet
        issue_request(mk_req(ght_pkg::OP_ADD, 0, 0, '1, 1'b1));          // slot 0, gen 1
        issue_request(mk_req(ght_pkg::OP_ADD, '1, '1, '0, 1'b1));        // slot 1, gen 1
        issue_request(mk_req(ght_pkg::OP_GET, 0, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_CONTAINS, 1, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_CONTAINS, 1, 0, '0, 1'b1));     // zero generation
        issue_request(mk_req(ght_pkg::OP_UPDATE, 0, 1, w, 1'b0));        // bad descriptor
        issue_request(mk_req(ght_pkg::OP_UPDATE, 0, 2, w, 1'b0));        // descriptor wins
        issue_request(mk_req(ght_pkg::OP_UPDATE, 0, 1, w, 1'b1));
        issue_request(mk_req(ght_pkg::OP_GET, 0, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_GET, '1, '1, '1, 1'b1));        // beyond claimed slots
        issue_request(mk_req(OP_UNDEF_LO, $urandom, $urandom, '1, 1'b1));
        issue_request(mk_req(OP_UNDEF_HI, 0, 1, w, 1'b0));
        issue_request(mk_req(ght_pkg::OP_DESTROY, 0, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_DESTROY, 0, 1, '0, 1'b0));      // already gone
        issue_request(mk_req(ght_pkg::OP_GET, 0, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_ADD, 0, 0, w, 1'b1));           // reuses slot 0, gen 2
        issue_request(mk_req(ght_pkg::OP_GET, 0, 2, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_DESTROY, 2, 1, '0, 1'b0));      // never claimed
        issue_request(mk_req(ght_pkg::OP_CLEAR, $urandom, $urandom, '1, 1'b0));
        issue_request(mk_req(ght_pkg::OP_CONTAINS, 1, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_ADD, 0, 0, ~w, 1'b1));          // slot 0 back at gen 1
        issue_request(mk_req(ght_pkg::OP_GET, 0, 1, '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_UPDATE, '1, '1, '1, 1'b1));
    endtask

    // Fill every slot, hit the full case, then free three and check LIFO reuse.
    task automatic test_fill_table;
        int victims[3];
        victims = '{5, 40, ght_pkg::SLOTS - 1};
        issue_request(mk_req(ght_pkg::OP_CLEAR, 0, 0, '0, 1'b0));
        for (int k = 0; k < ght_pkg::SLOTS + 2; k++)
            issue_request(mk_req(ght_pkg::OP_ADD, $urandom, $urandom,
                                 {$urandom, $urandom}, 1'b1));
        foreach (victims[k])
            issue_request(mk_req(ght_pkg::OP_DESTROY, victims[k], slot_gen[victims[k]],
                                 '0, 1'b0));
        issue_request(mk_req(ght_pkg::OP_GET, victims[1],
                             slot_gen[victims[1]] - ght_pkg::GEN_W'(1), '0, 1'b0));
        for (int k = 0; k < 4; k++)
            issue_request(mk_req(ght_pkg::OP_ADD, 0, 0, {$urandom, $urandom}, 1'b1));
    endtask

    task automatic run_mixed_traffic(input int items, input int idle_pct,
                                     input int stall_pct, input int add_w);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < items; k++)
        begin
            sender_gap();
            issue_request(compose_request(add_w));
        end
    endtask

    // Receiver holds off long enough for the block to back up into its input.
    task automatic test_output_stall;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < 40; k++)
            issue_request(compose_request(40));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side: ready generation, checking, watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ght_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = predicted_outcomes.pop_front();
                results_checked++;
                check_field("success", 64'(want.success), 64'(m_axis_tuser[0]));
                check_field("status", 64'(want.status), 64'(m_axis_tuser[2:1]));
                check_field("new_index", 64'(want.new_index), 64'(m_axis_tdata[5:0]));
                check_field("new_generation", 64'(want.new_generation),
                            64'(m_axis_tdata[37:6]));
                check_field("read_data", want.read_data, m_axis_tdata[101:38]);
                check_field("live_count", 64'(want.live_count),
                            64'(m_axis_tdata[108:102]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, predicted_outcomes.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_table();
        run_mixed_traffic(400, 0, 0, 40);
        run_mixed_traffic(350, 66, 0, 55);
        wait_drained();
        run_mixed_traffic(350, 0, 66, 30);
        test_output_stall();
        run_mixed_traffic(350, 26, 26, 45);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d requests, %0d results checked: %0d adds granted, %0d table full,",
                 requests_sent, results_checked, adds_granted, full_hits);
        $display("%0d stale handles, %0d bad descriptors, %0d clears, %0d undefined ops",
                 stale_hits, bad_desc_hits, clears_seen, undef_seen);
        if (errors == 0 && predicted_outcomes.size() == 0)
            $display("Regression PASS");
        else
        begin
            if (predicted_outcomes.size() != 0)
                $display("%0t: %0d results never arrived", $time, predicted_outcomes.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
